>>> design/cmc_pkg.sv
// Shared types and constants for the contiguous message coalescer.
package cmc_pkg;

   // Lanes in one wave; lane numbers and counts use the fixed field widths below
   localparam int WAVE_LANES = 64;

   localparam int LANE_W  = 6;
   localparam int PE_W    = 16;
   localparam int ADDR_W  = 64;
   localparam int SIZE_W  = 32;
   localparam int COUNT_W = 7;
   localparam int TOTAL_W = 38;

   // Depth of the queue between front and back
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // One closed run, ready to be sent as a merged message
   typedef struct packed {
      logic [LANE_W-1:0]  lead_lane;
      logic [PE_W-1:0]    pe;
      logic [ADDR_W-1:0]  src;
      logic [ADDR_W-1:0]  dst;
      logic [SIZE_W-1:0]  size;
      logic [COUNT_W-1:0] count;
   } run_rec_type;

   // All runs closed by one lane: one or two records
   typedef struct packed {
      logic        two;
      run_rec_type rec0;
      run_rec_type rec1;
   } run_entry_type;

   // Queue write side
   typedef struct packed {
      logic          push;
      run_entry_type entry;
   } q_wr_type;

   // Queue read side
   typedef struct packed {
      logic          valid;
      run_entry_type entry;
   } q_rd_type;

endpackage

>>> design/cmc_front.sv
// Front end: accepts lanes, tracks the open run and queues closed runs.
module cmc_front
   import cmc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                q_full,
   input  logic                req_lane_active,
   input  logic [PE_W-1:0]     req_dest_pe,
   input  logic [ADDR_W-1:0]   req_src_addr,
   input  logic [ADDR_W-1:0]   req_dst_addr,
   input  logic [SIZE_W-1:0]   req_msg_size,
   input  logic                req_last_lane,
   output logic                req_stall,
   output q_wr_type            q_wr
);

   logic                run_open_ff, run_open_in;
   logic [LANE_W-1:0]   lane_ff, lane_in;
   logic [PE_W-1:0]     prev_pe_ff, prev_pe_in;
   logic [ADDR_W-1:0]   prev_src_ff, prev_src_in;
   logic [ADDR_W-1:0]   prev_dst_ff, prev_dst_in;
   logic [SIZE_W-1:0]   prev_size_ff, prev_size_in;
   logic [LANE_W-1:0]   lead_lane_ff, lead_lane_in;
   logic [ADDR_W-1:0]   lead_src_ff, lead_src_in;
   logic [ADDR_W-1:0]   lead_dst_ff, lead_dst_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic                accept;
   logic                ends_wave;
   logic                joins;
   logic                closes_prev;
   logic                has_result;
   logic [ADDR_W-1:0]   src_next;
   logic [ADDR_W-1:0]   dst_next;
   run_rec_type         close_rec;
   run_rec_type         own_rec;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // Wave ends on the flagged lane or on the top lane
   assign ends_wave = req_last_lane ||
                      ({1'b0, lane_ff} >= COUNT_W'(WAVE_LANES - 1));

   // Neighbor compare: next addresses of the lane below
   assign src_next = prev_src_ff + ADDR_W'(req_msg_size);
   assign dst_next = prev_dst_ff + ADDR_W'(req_msg_size);
   assign joins    = run_open_ff && (lane_ff != '0) &&
                     (prev_pe_ff == req_dest_pe) && (prev_size_ff == req_msg_size) &&
                     (src_next == req_src_addr) && (dst_next == req_dst_addr);

   assign closes_prev = run_open_ff && (!req_lane_active || !joins);

   // Run state after this lane
   always_comb begin
      lead_lane_in = lead_lane_ff;
      lead_src_in  = lead_src_ff;
      lead_dst_in  = lead_dst_ff;
      count_in     = count_ff;
      prev_pe_in   = prev_pe_ff;
      prev_src_in  = prev_src_ff;
      prev_dst_in  = prev_dst_ff;
      prev_size_in = prev_size_ff;
      if (req_lane_active) begin
         if (joins) begin
            count_in = count_ff + COUNT_W'(1);
         end else begin
            lead_lane_in = lane_ff;
            lead_src_in  = req_src_addr;
            lead_dst_in  = req_dst_addr;
            count_in     = COUNT_W'(1);
         end
         prev_pe_in   = req_dest_pe;
         prev_src_in  = req_src_addr;
         prev_dst_in  = req_dst_addr;
         prev_size_in = req_msg_size;
      end
      run_open_in = req_lane_active && !ends_wave;
      lane_in     = ends_wave ? '0 : lane_ff + LANE_W'(1);
   end

   // Records for the run closed below and the run this lane closes
   always_comb begin
      close_rec.lead_lane = lead_lane_ff;
      close_rec.pe        = prev_pe_ff;
      close_rec.src       = lead_src_ff;
      close_rec.dst       = lead_dst_ff;
      close_rec.size      = prev_size_ff;
      close_rec.count     = count_ff;

      own_rec.lead_lane   = lead_lane_in;
      own_rec.pe          = req_dest_pe;
      own_rec.src         = lead_src_in;
      own_rec.dst         = lead_dst_in;
      own_rec.size        = req_msg_size;
      own_rec.count       = count_in;
   end

   // Queue write
   always_comb begin
      if (req_lane_active) begin
         has_result = closes_prev || ends_wave;
      end else begin
         has_result = run_open_ff;
      end
      q_wr.push       = accept && has_result;
      q_wr.entry.two  = req_lane_active && closes_prev && ends_wave;
      q_wr.entry.rec0 = closes_prev ? close_rec : own_rec;
      q_wr.entry.rec1 = own_rec;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_open_ff <= 1'b0;
         lane_ff     <= '0;
      end else if (accept) begin
         run_open_ff <= run_open_in;
         lane_ff     <= lane_in;
      end
   end

   // Run payload
   always_ff @(posedge clock) begin
      if (accept) begin
         prev_pe_ff   <= prev_pe_in;
         prev_src_ff  <= prev_src_in;
         prev_dst_ff  <= prev_dst_in;
         prev_size_ff <= prev_size_in;
         lead_lane_ff <= lead_lane_in;
         lead_src_ff  <= lead_src_in;
         lead_dst_ff  <= lead_dst_in;
         count_ff     <= count_in;
      end
   end

endmodule

>>> design/cmc_queue.sv
// Short queue of closed runs between front and back.
module cmc_queue
   import cmc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  q_wr_type  q_wr,
   input  logic      pop,
   output logic      full,
   output q_rd_type  q_rd
);

   run_entry_type       slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push;
   logic                do_pop;

   assign full       = (cnt_ff == QCNT_W'(QDEPTH));
   assign q_rd.valid = (cnt_ff != '0);
   assign q_rd.entry = slot_ff[rd_ptr_ff];

   assign do_push = q_wr.push && !full;
   assign do_pop  = pop && q_rd.valid;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + QCNT_W'(1);
         2'b01:   cnt_in = cnt_ff - QCNT_W'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_wr.entry;
      end
   end

endmodule

>>> design/cmc_back.sv
// Back end: sends queued runs one record at a time through the output register.
module cmc_back
   import cmc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  q_rd_type             q_rd,
   output logic                 pop,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [LANE_W-1:0]    rsp_leader_lane,
   output logic [PE_W-1:0]      rsp_out_pe,
   output logic [ADDR_W-1:0]    rsp_out_src_addr,
   output logic [ADDR_W-1:0]    rsp_out_dst_addr,
   output logic [TOTAL_W-1:0]   rsp_total_bytes,
   output logic [COUNT_W-1:0]   rsp_merged_count,
   output logic                 rsp_last_result
);

   logic                rsp_valid_ff, rsp_valid_in;
   logic                sel_ff, sel_in;
   logic [LANE_W-1:0]   lane_ff;
   logic [PE_W-1:0]     pe_ff;
   logic [ADDR_W-1:0]   src_ff;
   logic [ADDR_W-1:0]   dst_ff;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  count_ff;
   logic                last_ff, last_in;
   logic                load;
   run_rec_type         rec;

   assign load = !rsp_valid_ff || !rsp_stall;
   assign rec  = sel_ff ? q_rd.entry.rec1 : q_rd.entry.rec0;

   // Record select and queue pop
   always_comb begin
      last_in      = sel_ff || !q_rd.entry.two;
      pop          = load && q_rd.valid && last_in;
      rsp_valid_in = load ? q_rd.valid : rsp_valid_ff;
      sel_in       = sel_ff;
      if (load && q_rd.valid) begin
         sel_in = !last_in;
      end
      total_in = TOTAL_W'({{(TOTAL_W-SIZE_W){1'b0}}, rec.size} *
                          {{(TOTAL_W-COUNT_W){1'b0}}, rec.count});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (load && q_rd.valid) begin
         lane_ff  <= rec.lead_lane;
         pe_ff    <= rec.pe;
         src_ff   <= rec.src;
         dst_ff   <= rec.dst;
         total_ff <= total_in;
         count_ff <= rec.count;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_leader_lane  = lane_ff;
   assign rsp_out_pe       = pe_ff;
   assign rsp_out_src_addr = src_ff;
   assign rsp_out_dst_addr = dst_ff;
   assign rsp_total_bytes  = total_ff;
   assign rsp_merged_count = count_ff;
   assign rsp_last_result  = last_ff;

endmodule

>>> design/contiguous_message_coalescer.sv
// Top level of the contiguous message coalescer.
// Path: a closing lane's run is written to the queue, then to the output register.
// Throughput: one lane per cycle unless req_stall; results one per cycle unless
// rsp_stall; two runs closed by one lane leave in turn from the 4-entry run queue.
// Reset: synchronous, active high; clears the open run, lane index, queue and
// output valid. No clearing pass is needed.
module contiguous_message_coalescer
   import cmc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_lane_active,
   input  logic [PE_W-1:0]      req_dest_pe,
   input  logic [ADDR_W-1:0]    req_src_addr,
   input  logic [ADDR_W-1:0]    req_dst_addr,
   input  logic [SIZE_W-1:0]    req_msg_size,
   input  logic                 req_last_lane,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [LANE_W-1:0]    rsp_leader_lane,
   output logic [PE_W-1:0]      rsp_out_pe,
   output logic [ADDR_W-1:0]    rsp_out_src_addr,
   output logic [ADDR_W-1:0]    rsp_out_dst_addr,
   output logic [TOTAL_W-1:0]   rsp_total_bytes,
   output logic [COUNT_W-1:0]   rsp_merged_count,
   output logic                 rsp_last_result
);

   q_wr_type q_wr;
   q_rd_type q_rd;
   logic     q_full;
   logic     q_pop;

   cmc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .q_full          (q_full),
      .req_lane_active (req_lane_active),
      .req_dest_pe     (req_dest_pe),
      .req_src_addr    (req_src_addr),
      .req_dst_addr    (req_dst_addr),
      .req_msg_size    (req_msg_size),
      .req_last_lane   (req_last_lane),
      .req_stall       (req_stall),
      .q_wr            (q_wr)
   );

   cmc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .q_wr  (q_wr),
      .pop   (q_pop),
      .full  (q_full),
      .q_rd  (q_rd)
   );

   cmc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_rd             (q_rd),
      .pop              (q_pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_leader_lane  (rsp_leader_lane),
      .rsp_out_pe       (rsp_out_pe),
      .rsp_out_src_addr (rsp_out_src_addr),
      .rsp_out_dst_addr (rsp_out_dst_addr),
      .rsp_total_bytes  (rsp_total_bytes),
      .rsp_merged_count (rsp_merged_count),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

>>> design/cmc_checker.sv
// Port-level checks for the contiguous message coalescer, bound to the top level.
module cmc_checker
   import cmc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [LANE_W-1:0]   rsp_leader_lane,
   input logic [ADDR_W-1:0]   rsp_out_src_addr,
   input logic [TOTAL_W-1:0]  rsp_total_bytes,
   input logic [COUNT_W-1:0]  rsp_merged_count
);

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_src_addr) &&
                                 $stable(rsp_total_bytes))
      else $error("stalled result changed");

   // Nothing is shown right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // A run holds at least one lane and fits in the wave
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_merged_count != '0) &&
                    (({2'b00, rsp_leader_lane} + {1'b0, rsp_merged_count}) <=
                     (COUNT_W + 1)'(WAVE_LANES)))
      else $error("run lanes out of wave");

   // A one-lane run carries no more than one size worth of bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_merged_count == COUNT_W'(1)) |->
         (rsp_total_bytes[TOTAL_W-1:SIZE_W] == '0))
      else $error("one-lane total too large");

endmodule

bind contiguous_message_coalescer cmc_checker u_cmc_checker (.*);
